// ===== design/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Geometry constants, field widths, action codes, character codes and register indices of the text console engine.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [2:0] ACT_PUT   = 3'd0;
    localparam logic [2:0] ACT_DRAW  = 3'd1;
    localparam logic [2:0] ACT_SETCUR = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    localparam logic [0:0] REG_TEXT_COLOR    = 1'd0;
    localparam logic [0:0] REG_CURSOR_ENABLE = 1'd1;

    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [POS_W-1:0] POS_END    = POS_W'(CELL_COUNT);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(CELL_COUNT - 1);
    localparam logic [POS_W-1:0] POS_ROWLEN = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0] POS_LASTROW = POS_W'(CELL_COUNT - COLUMNS);
    localparam logic [POS_W-1:0] POS_HIDDEN = POS_W'(CELL_COUNT + 1);

    // Linear cell index; the constant multiply reduces to shifts and adds.
    function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        cell_pos = POS_W'(r) * POS_ROWLEN + POS_W'(c);
    endfunction

endpackage

// ===== design/text_console_engine_core.sv =====
// ----------------------------------------------------------------------------
// text_console_engine_core
// Character-cell console over a single-port-write, one-read screen memory.
// ----------------------------------------------------------------------------
// Each accepted word passes to the finish state, which registers the result word
// once the output register is free; no new word is taken until the engine is idle again.
// A put byte that scrolls first runs a copy pass, then writes a row of blanks (one
// memory write per cycle); clear screen blanks every cell the same way.
// Reset: cursor at row 0 column 0, text_color 15, cursor shown; the screen
// memory holds undefined contents until cleared or written.
module text_console_engine_core
    import tce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[2:0], byte_value[10:3], row[15:11], col[22:16], color[30:23], zero[31]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_row[4:0], cursor_col[11:5], hw_cursor[22:12], read_byte[30:23],
    // status[31]
    output logic [31:0] m_tdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FINISH = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_BLANK  = 2'd3;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [POS_W-1:0]  cur_pos_reg, cur_pos_next;
    logic [7:0]        text_color_reg;
    logic              cursor_enable_reg;
    logic              status_reg, status_next;
    logic              rd_sel_reg, rd_sel_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic              copy_vld_reg, copy_vld_next;
    logic [POS_W-1:0]  copy_dst_reg, copy_dst_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic              mem_we, mem_re;
    logic [POS_W-1:0]  mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic [2:0]        in_action;
    logic [CHAR_W-1:0] in_byte;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [7:0]        in_color;
    logic              accept;
    logic              in_range;
    logic [POS_W-1:0]  in_pos;
    logic [POS_W-1:0]  hw_cursor;
    logic [CHAR_W-1:0] read_byte;

    assign in_action = s_tdata[2:0];
    assign in_byte   = s_tdata[10:3];
    assign in_row    = s_tdata[15:11];
    assign in_col    = s_tdata[22:16];
    assign in_color  = s_tdata[30:23];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (in_row <= LAST_ROW) && (in_col <= LAST_COL);
    assign in_pos   = cell_pos(in_row, in_col);

    assign hw_cursor = cursor_enable_reg ? cur_pos_reg : POS_HIDDEN;
    assign read_byte = rd_sel_reg ? rdata_reg[CHAR_W-1:0] : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        cur_pos_next  = cur_pos_reg;
        status_next   = status_reg;
        rd_sel_next   = rd_sel_reg;
        cnt_next      = cnt_reg;
        copy_vld_next = 1'b0;
        copy_dst_next = copy_dst_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_pos_reg;
        mem_wdata     = {text_color_reg, CH_BLANK};
        mem_re        = 1'b0;
        mem_raddr     = in_pos;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_FINISH;
                    status_next = 1'b0;
                    rd_sel_next = 1'b0;
                    case (in_action)
                        ACT_PUT:
                        begin
                            if (in_byte == CH_NEWLINE)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    cur_pos_next = cur_pos_reg - POS_W'(cur_col_reg);
                                    state_next   = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    cur_pos_next = cur_pos_reg - POS_W'(cur_col_reg)
                                                   + POS_ROWLEN;
                                end
                            end
                            else if (in_byte == CH_RETURN)
                            begin
                                cur_col_next = '0;
                                cur_pos_next = cur_pos_reg - POS_W'(cur_col_reg);
                            end
                            else if (in_byte == CH_BACKSPACE)
                            begin
                                if (cur_pos_reg != '0)
                                begin
                                    cur_pos_next = cur_pos_reg - 1'b1;
                                    if (cur_col_reg == '0)
                                    begin
                                        cur_col_next = LAST_COL;
                                        cur_row_next = cur_row_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        cur_col_next = cur_col_reg - 1'b1;
                                    end
                                end
                                mem_we    = 1'b1;
                                mem_waddr = cur_pos_next;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_pos_reg;
                                mem_wdata = {text_color_reg, in_byte};
                                if (cur_col_reg == LAST_COL)
                                begin
                                    cur_col_next = '0;
                                    if (cur_row_reg == LAST_ROW)
                                    begin
                                        cur_pos_next = POS_LASTROW;
                                        state_next   = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        cur_row_next = cur_row_reg + 1'b1;
                                        cur_pos_next = cur_pos_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                    cur_pos_next = cur_pos_reg + 1'b1;
                                end
                            end
                            cnt_next = POS_ROWLEN;
                        end
                        ACT_DRAW:
                        begin
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = in_pos;
                                mem_wdata = {in_color, in_byte};
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        ACT_SETCUR:
                        begin
                            if (in_range)
                            begin
                                cur_row_next = in_row;
                                cur_col_next = in_col;
                                cur_pos_next = in_pos;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        ACT_READ:
                        begin
                            if (in_range)
                            begin
                                mem_re      = 1'b1;
                                rd_sel_next = 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                            cur_pos_next = '0;
                            cnt_next     = '0;
                            state_next   = ST_BLANK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // Reads run one row ahead of writes, so a copy never sees stale data.
                if (copy_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = copy_dst_reg;
                    mem_wdata = rdata_reg;
                end
                if (cnt_reg == POS_END)
                begin
                    cnt_next   = POS_LASTROW;
                    state_next = ST_BLANK;
                end
                else
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg;
                    copy_vld_next = 1'b1;
                    copy_dst_next = cnt_reg - POS_ROWLEN;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == POS_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {status_reg, read_byte, hw_cursor,
                                     cur_col_reg, cur_row_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cur_row_reg       <= '0;
            cur_col_reg       <= '0;
            cur_pos_reg       <= '0;
            text_color_reg    <= 8'd15;
            cursor_enable_reg <= 1'b1;
            m_tvalid_reg      <= 1'b0;
            copy_vld_reg      <= 1'b0;
            status_reg        <= 1'b0;
            rd_sel_reg        <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            cur_pos_reg  <= cur_pos_next;
            m_tvalid_reg <= m_tvalid_next;
            copy_vld_reg <= copy_vld_next;
            status_reg   <= status_next;
            rd_sel_reg   <= rd_sel_next;
            cnt_reg      <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEXT_COLOR:    text_color_reg    <= cfg_wdata;
                    REG_CURSOR_ENABLE: cursor_enable_reg <= cfg_wdata[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= copy_dst_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Screen store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== verif/text_console_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_engine_core_tb
// Self-checking bench for the text console engine. Command words go in on
// the slave stream, and a shadow of the screen, cursor and registers predicts
// every status word. Directed tests cover control characters, scrolling,
// bounds and the hidden cursor. Random traffic then runs with idle and stall
// patterns on both sides, a long output stall, and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_engine_core_tb;
    import tce_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int         MAX_PRINTS   = 40;

    // Listed from the high bits down; action lands in bit 0.
    typedef struct packed {
        logic [7:0]       color;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       ch;
        logic [2:0]       action;
    } console_cmd_t;

    typedef struct packed {
        logic             status;
        logic [7:0]       read_byte;
        logic [POS_W-1:0] hw_cursor;
        logic [COL_W-1:0] cur_col;
        logic [ROW_W-1:0] cur_row;
    } console_view_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // Shadow of the engine state.
    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    int unsigned       cur_pos;
    logic [7:0]        color_reg;
    logic              cursor_shown;

    console_view_t expected_views[$];

    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold;

    int word_count;
    int checked_count;
    int mismatch_count;
    int scroll_count;
    int clear_count;
    int read_count;
    int reject_count;

    text_console_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("text_console_engine_core_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void scroll_screen();
        int i;
        for (i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_mem[i] = screen_mem[i + COLUMNS];
        for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_mem[i] = {color_reg, CH_BLANK};
        cur_pos -= COLUMNS;
        scroll_count++;
    endfunction

    function automatic void print_char(input logic [7:0] ch);
        int unsigned col_now;
        col_now = cur_pos % COLUMNS;
        if (ch == CH_NEWLINE)
            cur_pos += COLUMNS - col_now;
        else if (ch == CH_RETURN)
            cur_pos -= col_now;
        else if (ch == CH_BACKSPACE)
        begin
            if (cur_pos != 0)
                cur_pos--;
            screen_mem[cur_pos] = {color_reg, CH_BLANK};
        end
        else
        begin
            screen_mem[cur_pos] = {color_reg, ch};
            cur_pos++;
        end
        if (cur_pos >= CELL_COUNT)
            scroll_screen();
    endfunction

    function automatic console_view_t predict_view(input console_cmd_t cmd);
        console_view_t view;
        logic          in_range;
        int unsigned   cell_idx;
        int            i;
        view     = '0;
        in_range = (cmd.row < ROWS) && (cmd.col < COLUMNS);
        cell_idx = cmd.row * COLUMNS + cmd.col;
        case (cmd.action)
            ACT_PUT:
                print_char(cmd.ch);
            ACT_DRAW:
                if (in_range)
                    screen_mem[cell_idx] = {cmd.color, cmd.ch};
                else
                    view.status = 1'b1;
            ACT_SETCUR:
                if (in_range)
                    cur_pos = cell_idx;
                else
                    view.status = 1'b1;
            ACT_READ:
            begin
                read_count++;
                if (in_range)
                    view.read_byte = screen_mem[cell_idx][7:0];
                else
                    view.status = 1'b1;
            end
            ACT_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                    screen_mem[i] = {color_reg, CH_BLANK};
                cur_pos = 0;
                clear_count++;
            end
            default:
                ;
        endcase
        if (view.status)
            reject_count++;
        view.cur_row   = ROW_W'(cur_pos / COLUMNS);
        view.cur_col   = COL_W'(cur_pos % COLUMNS);
        view.hw_cursor = cursor_shown ? POS_W'(cur_pos) : POS_HIDDEN;
        return view;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers and checker
    // ------------------------------------------------------------------------
    function automatic console_cmd_t make_cmd(input logic [2:0] action,
                                              input logic [7:0] ch,
                                              input int unsigned row,
                                              input int unsigned col,
                                              input logic [7:0] color);
        console_cmd_t cmd;
        cmd.action = action;
        cmd.ch     = ch;
        cmd.row    = ROW_W'(row);
        cmd.col    = COL_W'(col);
        cmd.color  = color;
        return cmd;
    endfunction

    // Valid stays high after acceptance so that back-to-back words need no
    // bubble; whoever stops sending lowers it through wait_drained.
    task automatic send_word(input console_cmd_t cmd);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        expected_views.push_back(predict_view(cmd));
        word_count++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_views.size() != 0);
    endtask

    // Only called with the engine idle, so the shadow can follow at once.
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TEXT_COLOR)
            color_reg = value;
        else
            cursor_shown = value[0];
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, what, got,
                     want);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        console_view_t got;
        console_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_views.size() == 0)
                report_mismatch("unexpected word", m_tdata, 0);
            else
            begin
                want = expected_views.pop_front();
                checked_count++;
                if (got.cur_row !== want.cur_row)
                    report_mismatch("cursor_row", got.cur_row, want.cur_row);
                if (got.cur_col !== want.cur_col)
                    report_mismatch("cursor_col", got.cur_col, want.cur_col);
                if (got.hw_cursor !== want.hw_cursor)
                    report_mismatch("hw_cursor", got.hw_cursor, want.hw_cursor);
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The screen holds garbage after reset, so clearing comes before any read.
    task automatic test_clear_and_blank();
        write_reg(REG_TEXT_COLOR, 8'h07);
        write_reg(REG_CURSOR_ENABLE, 8'h01);
        send_word(make_cmd(ACT_CLEAR, 8'hFF, 31, 127, 8'hFF));
        send_word(make_cmd(ACT_READ, 8'h00, 0, 0, 8'h00));
        send_word(make_cmd(ACT_READ, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00));
    endtask

    task automatic test_put_controls();
        send_word(make_cmd(ACT_PUT, CH_BACKSPACE, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, 8'h41, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, 8'hFF, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, 8'h00, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, CH_BACKSPACE, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, CH_NEWLINE, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, 8'h42, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, CH_RETURN, 0, 0, 8'h00));
        send_word(make_cmd(ACT_READ, 8'h00, 0, 1, 8'h00));
    endtask

    task automatic test_draw_read_bounds();
        send_word(make_cmd(ACT_DRAW, 8'hFF, ROWS - 1, COLUMNS - 1, 8'h00));
        send_word(make_cmd(ACT_READ, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00));
        send_word(make_cmd(ACT_DRAW, 8'h00, 0, 0, 8'hFF));
        send_word(make_cmd(ACT_DRAW, 8'h55, ROWS, 0, 8'h11));
        send_word(make_cmd(ACT_DRAW, 8'h55, 0, COLUMNS, 8'h11));
        send_word(make_cmd(ACT_SETCUR, 8'h00, 31, 127, 8'h00));
        send_word(make_cmd(ACT_READ, 8'h00, ROWS, COLUMNS - 1, 8'h00));
    endtask

    task automatic test_scroll_at_end();
        send_word(make_cmd(ACT_SETCUR, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00));
        send_word(make_cmd(ACT_PUT, 8'h5A, 0, 0, 8'h00));
        send_word(make_cmd(ACT_PUT, CH_NEWLINE, 0, 0, 8'h00));
        send_word(make_cmd(ACT_READ, 8'h00, ROWS - 3, COLUMNS - 1, 8'h00));
    endtask

    task automatic test_spare_actions();
        logic [2:0] act;
        for (act = ACT_SPARE_LO; act != ACT_PUT; act++)
            send_word(make_cmd(act, 8'hFF, 31, 127, 8'hFF));
    endtask

    task automatic test_hidden_cursor();
        wait_drained();
        write_reg(REG_CURSOR_ENABLE, 8'h00);
        send_word(make_cmd(ACT_SETCUR, 8'h00, 12, 40, 8'h00));
        send_word(make_cmd(ACT_PUT, 8'h3F, 0, 0, 8'h00));
        wait_drained();
        write_reg(REG_CURSOR_ENABLE, 8'h01);
    endtask

    // Mostly in-range traffic that keeps the cursor moving and often parks it
    // on the last row, so newlines and printing wrap into scrolls.
    function automatic console_cmd_t random_cmd();
        console_cmd_t cmd;
        int unsigned  pick;
        int unsigned  flavor;
        cmd.ch    = 8'($urandom_range(0, 255));
        cmd.color = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
        begin
            cmd.row = ROW_W'($urandom_range(0, 31));
            cmd.col = COL_W'($urandom_range(0, 127));
        end
        else
        begin
            cmd.row = ROW_W'($urandom_range(0, ROWS - 1));
            cmd.col = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            cmd.action = ACT_PUT;
            flavor     = $urandom_range(0, 99);
            if (flavor < 16)
                cmd.ch = CH_NEWLINE;
            else if (flavor < 22)
                cmd.ch = CH_RETURN;
            else if (flavor < 32)
                cmd.ch = CH_BACKSPACE;
        end
        else if (pick < 63)
            cmd.action = ACT_DRAW;
        else if (pick < 73)
        begin
            cmd.action = ACT_SETCUR;
            if ($urandom_range(0, 2) == 0)
            begin
                cmd.row = LAST_ROW;
                cmd.col = COL_W'($urandom_range(COLUMNS - 8, COLUMNS - 1));
            end
        end
        else if (pick < 93)
            cmd.action = ACT_READ;
        else if (pick < 95)
            cmd.action = ACT_CLEAR;
        else
            cmd.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        return cmd;
    endfunction

    task automatic test_random_mix(input int count, input int src_pct, input int sink_pct,
                                   input logic [7:0] color, input logic shown);
        wait_drained();
        write_reg(REG_TEXT_COLOR, color);
        write_reg(REG_CURSOR_ENABLE, {7'd0, shown});
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
            send_word(random_cmd());
    endtask

    // The output side stops for a long while as words keep coming, so the
    // engine must hold its input off; then the sender waits for every result.
    task automatic test_output_stall();
        wait_drained();
        src_idle_pct = 0;
        sink_hold    = 300;
        repeat (12)
            send_word(random_cmd());
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        src_idle_pct  = 12;
        sink_idle_pct = 53;
        sink_hold     = 0;
        cur_pos       = 0;
        color_reg     = 8'd15;
        cursor_shown  = 1'b1;
        word_count     = 0;
        checked_count  = 0;
        mismatch_count = 0;
        scroll_count   = 0;
        clear_count    = 0;
        read_count     = 0;
        reject_count   = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_clear_and_blank();
        test_put_controls();
        test_draw_read_bounds();
        test_scroll_at_end();
        test_spare_actions();
        test_hidden_cursor();
        test_random_mix(300, 12, 53, 8'hFF, 1'b1);
        test_output_stall();
        test_random_mix(300, 53, 12, 8'h00, 1'b0);
        test_random_mix(300, 0, 0, 8'($urandom_range(1, 254)), 1'b1);

        wait_drained();
        repeat (16)
            @(posedge clk);

        $display("Sent %0d command words: %0d scrolls, %0d clears, %0d reads, %0d rejected.",
                 word_count, scroll_count, clear_count, read_count, reject_count);
        $display("Checked %0d status words, %0d field mismatches.", checked_count,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("text_console_engine_core_tb: PASS");
        else
            $display("text_console_engine_core_tb: FAIL");
        $finish;
    end

endmodule
